@@ rtl/lps_pkg.sv @@
// Shared constants for the line point stepper.
// No dependencies; used by every module of the block.
package lps_pkg;

    localparam int COORD_BITS_DEF = 6;
    // sy_neg, sx_neg, steep
    localparam int CMD_FLAG_BITS  = 3;
    localparam int QUEUE_DEPTH    = 2;

endpackage

@@ rtl/lps_front.sv @@
// Front end: accepts a start/end pair, derives major/minor lengths, steps and
// octant, drops zero-length lines and holds one command for the queue. Uses lps_pkg.
module lps_front #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF,
    parameter int CMD_W      = 4 * COORD_BITS + lps_pkg::CMD_FLAG_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [COORD_BITS-1:0]   start_x,
    input  logic [COORD_BITS-1:0]   start_y,
    input  logic [COORD_BITS-1:0]   end_x,
    input  logic [COORD_BITS-1:0]   end_y,
    output logic                    cmd_valid,
    input  logic                    cmd_ready,
    output logic [CMD_W-1:0]        cmd_data
);

    logic                  hold_valid_reg, hold_valid_next;
    logic [CMD_W-1:0]      cmd_reg;
    logic [COORD_BITS:0]   dx, dy, ndx, ndy;
    logic [COORD_BITS-1:0] adx, ady, major, minor;
    logic                  steep, accept, nonzero;

    assign dx  = {1'b0, end_x} - {1'b0, start_x};
    assign dy  = {1'b0, end_y} - {1'b0, start_y};
    assign ndx = -dx;
    assign ndy = -dy;
    assign adx = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    assign ady = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];

    // tie goes to x as major
    assign steep   = adx < ady;
    assign major   = steep ? ady : adx;
    assign minor   = steep ? adx : ady;
    assign nonzero = major != '0;

    assign in_ready  = !hold_valid_reg || cmd_ready;
    assign accept    = in_valid && in_ready;
    assign cmd_valid = hold_valid_reg;
    assign cmd_data  = cmd_reg;

    always_comb begin
        hold_valid_next = (hold_valid_reg && !cmd_ready) || (accept && nonzero);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && nonzero) begin
            cmd_reg <= {dy[COORD_BITS], dx[COORD_BITS], steep, minor, major,
                        start_y, start_x};
        end
    end

endmodule

@@ rtl/lps_queue.sv @@
// Short command queue between front and back ends.
// Register array with read/write pointers; uses lps_pkg for its depth.
module lps_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lps_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = count_reg != FULL_CNT;
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/lps_back.sv @@
// Back end: walks one line command a point per cycle while the output is
// not stalled, using the error accumulator; drives the registered output beat. Uses lps_pkg.
module lps_back #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF,
    parameter int CMD_W      = 4 * COORD_BITS + lps_pkg::CMD_FLAG_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  logic [CMD_W-1:0]      cmd_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_BITS-1:0] point_x,
    output logic [COORD_BITS-1:0] point_y,
    output logic                  last_point
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    logic [COORD_BITS-1:0] x_reg, y_reg, x_next, y_next;
    logic [COORD_BITS-1:0] acc_reg, acc_next, cnt_reg, cnt_next;
    logic [COORD_BITS-1:0] major_reg, minor_reg;
    logic                  steep_reg, sx_neg_reg, sy_neg_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] out_x_reg, out_y_reg;
    logic                  out_last_reg;
    logic                  can_load, emit, load_cmd, carry;
    logic [COORD_BITS:0]   acc_sum, acc_sub;
    logic [COORD_BITS-1:0] x_step, y_step;

    logic [COORD_BITS-1:0] c_x, c_y, c_major, c_minor;
    logic                  c_steep, c_sx_neg, c_sy_neg;

    assign {c_sy_neg, c_sx_neg, c_steep, c_minor, c_major, c_y, c_x} = cmd_data;

    assign can_load  = !out_valid_reg || out_ready;
    assign emit      = (state_reg == ST_RUN) && can_load;
    assign cmd_ready = state_reg == ST_IDLE;
    assign load_cmd  = cmd_valid && cmd_ready;

    assign acc_sum = {1'b0, acc_reg} + {1'b0, minor_reg};
    assign acc_sub = acc_sum - {1'b0, major_reg};
    assign carry   = acc_sum >= {1'b0, major_reg};
    assign x_step  = sx_neg_reg ? x_reg - 1'b1 : x_reg + 1'b1;
    assign y_step  = sy_neg_reg ? y_reg - 1'b1 : y_reg + 1'b1;

    always_comb begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (load_cmd) begin
                    x_next     = c_x;
                    y_next     = c_y;
                    acc_next   = c_major >> 1;
                    cnt_next   = c_major;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (emit) begin
                    if (steep_reg || carry) begin
                        y_next = y_step;
                    end
                    if (!steep_reg || carry) begin
                        x_next = x_step;
                    end
                    acc_next = carry ? acc_sub[COORD_BITS-1:0] : acc_sum[COORD_BITS-1:0];
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == COORD_BITS'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
        cnt_reg <= cnt_next;
        if (load_cmd) begin
            major_reg  <= c_major;
            minor_reg  <= c_minor;
            steep_reg  <= c_steep;
            sx_neg_reg <= c_sx_neg;
            sy_neg_reg <= c_sy_neg;
        end
        if (emit) begin
            out_x_reg    <= x_reg;
            out_y_reg    <= y_reg;
            out_last_reg <= cnt_reg == COORD_BITS'(1);
        end
    end

    assign out_valid  = out_valid_reg;
    assign point_x    = out_x_reg;
    assign point_y    = out_y_reg;
    assign last_point = out_last_reg;

endmodule

@@ rtl/line_point_stepper.sv @@
// Top level of the line point stepper: front end, command queue, back end.
// Depends on lps_pkg, lps_front, lps_queue and lps_back.
//
// Usage:
//   Slave stream (s_*) takes one beat per line: start and end grid points.
//   Master stream (m_*) gives one beat per line point, start point first,
//   end point left out; m_tlast marks the final point of a line. A line
//   with equal endpoints gives no beats.
//   Path: an input beat reaches the output through the front-end command
//   register, the queue, the stepper load state and the output register.
//   Throughput: the back-end stepper takes a line command in its idle
//   state, then gives one point per cycle while m_tready does not stall it;
//   a line has up to 63 points at 6-bit coordinates. The front end and a
//   two-entry queue take further lines while the stepper works.
//   Reset: synchronous, active low; clears the queue, the stepper and the
//   output register. No state is kept between lines.
//   Stall: when m_tready is low the output beat holds; the stepper, then
//   the queue and finally s_tready back up in turn.
module line_point_stepper #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // start_x, start_y, end_x, end_y (low to high), zero padded
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]          s_tdata,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // point_x, point_y (low to high), zero padded
    output logic [((2*COORD_BITS+7)/8)*8-1:0]          m_tdata,
    output logic                                       m_tlast
);

    localparam int CMD_W   = 4 * COORD_BITS + lps_pkg::CMD_FLAG_BITS;
    localparam int M_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

    logic                  f_valid, f_ready, b_valid, b_ready;
    logic [CMD_W-1:0]      f_data, b_data;
    logic [COORD_BITS-1:0] point_x, point_y;

    lps_front #(
        .COORD_BITS (COORD_BITS),
        .CMD_W      (CMD_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .start_x   (s_tdata[COORD_BITS-1:0]),
        .start_y   (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .end_x     (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .end_y     (s_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd_data  (f_data)
    );

    lps_queue #(
        .WIDTH (CMD_W),
        .DEPTH (lps_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    lps_back #(
        .COORD_BITS (COORD_BITS),
        .CMD_W      (CMD_W)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (b_valid),
        .cmd_ready  (b_ready),
        .cmd_data   (b_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .point_x    (point_x),
        .point_y    (point_y),
        .last_point (m_tlast)
    );

    assign m_tdata = M_DATA_W'({point_y, point_x});

endmodule

@@ rtl/lps_checker.sv @@
// Port-level checks for line_point_stepper, bound to every instance.
// Depends on lps_pkg for the default coordinate width.
module lps_checker #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [((2*COORD_BITS+7)/8)*8-1:0]   m_tdata,
    input logic                                m_tlast
);

    logic [COORD_BITS-1:0] prev_x_reg, prev_y_reg, cur_x, cur_y;
    logic                  open_reg;
    logic                  out_beat, step_ok, x_near, y_near;

    assign out_beat = m_tvalid && m_tready;
    assign cur_x    = m_tdata[COORD_BITS-1:0];
    assign cur_y    = m_tdata[2*COORD_BITS-1:COORD_BITS];
    assign x_near   = (cur_x == prev_x_reg) || (cur_x == prev_x_reg + 1'b1)
                   || (cur_x == prev_x_reg - 1'b1);
    assign y_near   = (cur_y == prev_y_reg) || (cur_y == prev_y_reg + 1'b1)
                   || (cur_y == prev_y_reg - 1'b1);
    assign step_ok  = x_near && y_near && !(cur_x == prev_x_reg && cur_y == prev_y_reg);

    // open_reg: previous beat belonged to a line that is not finished
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= 1'b0;
        end else if (out_beat) begin
            open_reg <= !m_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_beat) begin
            prev_x_reg <= cur_x;
            prev_y_reg <= cur_y;
        end
    end

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output beat valid right after reset");

    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready right after reset");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output beat changed");

    a_adjacent_points: assert property (@(posedge aclk) disable iff (!aresetn)
        out_beat && open_reg |-> step_ok)
        else $error("consecutive line points are not neighbors");

endmodule

bind line_point_stepper lps_checker #(
    .COORD_BITS (COORD_BITS)
) u_lps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
